>>> rtl/attack_release_envelope_follower_unit_defines.svh
// assertion macros shared by the envelope follower rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef ATTACK_RELEASE_ENVELOPE_FOLLOWER_UNIT_DEFINES_SVH
`define ATTACK_RELEASE_ENVELOPE_FOLLOWER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define ARFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ARFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/arfe_pkg.sv
// shared types, constants and the microcode rom of the envelope follower
// no dependencies
package arfe_pkg;

  localparam int unsigned PC_W    = 4;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned COEFF_W = 17;
  localparam int unsigned ENV_W   = 48;
  localparam int unsigned MAG_W   = 17;
  localparam int unsigned DET_W   = 31;
  localparam int unsigned PROD_W  = ENV_W + COEFF_W;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COEFF_W-1:0] COEFF_ONE  = 17'h10000;
  localparam logic [CNT_W-1:0]   MUL_LAST   = 5'd16;
  localparam logic [CNT_W-1:0]   SQRT_LAST  = 5'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ATTACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELEASE = 2'd2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD_IN,
    OP_MUL_STEP,
    OP_DET_PROD,
    OP_DIFF,
    OP_UPDATE,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_EMIT_ROOT,
    OP_EMIT_PEAK
  } arfe_op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_PEAK,
    COND_CNT_NZ,
    COND_OUT_FULL
  } arfe_cond_e;

  typedef struct packed {
    arfe_op_e        op;
    arfe_cond_e      cond;
    logic [PC_W-1:0] target;
  } arfe_ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic peak_mode;
    logic out_full;
  } arfe_stat_t;

  // microprogram: jump to target when cond holds, else fall through
  function automatic arfe_ctrl_t rom(input logic [PC_W-1:0] pc);
    arfe_ctrl_t w;
    unique case (pc)
      4'd0:    w = '{OP_LOAD_IN,   COND_NO_IN,    4'd0};
      4'd1:    w = '{OP_NOP,       COND_PEAK,     4'd4};
      4'd2:    w = '{OP_MUL_STEP,  COND_CNT_NZ,   4'd2};
      4'd3:    w = '{OP_DET_PROD,  COND_NEVER,    4'd0};
      4'd4:    w = '{OP_DIFF,      COND_NEVER,    4'd0};
      4'd5:    w = '{OP_MUL_STEP,  COND_CNT_NZ,   4'd5};
      4'd6:    w = '{OP_UPDATE,    COND_NEVER,    4'd0};
      4'd7:    w = '{OP_SQRT_INIT, COND_PEAK,     4'd11};
      4'd8:    w = '{OP_SQRT_STEP, COND_CNT_NZ,   4'd8};
      4'd9:    w = '{OP_EMIT_ROOT, COND_OUT_FULL, 4'd9};
      4'd11:   w = '{OP_EMIT_PEAK, COND_OUT_FULL, 4'd11};
      default: w = '{OP_NOP,       COND_ALWAYS,   4'd0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/attack_release_envelope_follower_unit.sv
// Attack/release envelope follower. One signed 16-bit sample in, one
// envelope level out per transaction. A microcoded sequencer drives a shared
// shift-add multiplier (17 steps per product) and a two-bit-per-step square
// root (16 steps). A result waits in the output register until it is
// read. A new sample is taken while the previous result still waits.
// Registers: 0 detector mode, 1 attack and 2 release coefficient (Q1.16).
// Depends on arfe_pkg, arfe_seq and arfe_dpath.

module attack_release_envelope_follower_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [15:0]                   sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [arfe_pkg::LEVEL_W-1:0]         envelope_level_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [arfe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [arfe_pkg::COEFF_W-1:0]         cfg_data_i
);

  logic                         mode_q;
  logic [arfe_pkg::COEFF_W-1:0] attack_q;
  logic [arfe_pkg::COEFF_W-1:0] release_q;
  arfe_pkg::arfe_ctrl_t         ctrl;
  arfe_pkg::arfe_stat_t         stat;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      attack_q  <= arfe_pkg::COEFF_ONE;
      release_q <= arfe_pkg::COEFF_ONE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        arfe_pkg::CFG_IDX_MODE:    mode_q    <= cfg_data_i[0];
        arfe_pkg::CFG_IDX_ATTACK:  attack_q  <= cfg_data_i;
        arfe_pkg::CFG_IDX_RELEASE: release_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  arfe_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_ready_o (in_ready_o)
  );

  // datapath
  arfe_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (sample_i),
    .mode_i      (mode_q),
    .attack_i    (attack_q),
    .release_i   (release_q),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .level_o     (envelope_level_o)
  );

endmodule

>>> rtl/arfe_seq.sv
// microcode sequencer: step counter, rom lookup and conditional jumps
// depends on arfe_pkg and the shared assertion macros
`include "attack_release_envelope_follower_unit_defines.svh"

module arfe_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  arfe_pkg::arfe_stat_t stat_i,
  output arfe_pkg::arfe_ctrl_t ctrl_o,
  output logic                 in_ready_o
);

  logic [arfe_pkg::PC_W-1:0] pc_q, pc_d;
  arfe_pkg::arfe_ctrl_t      word;
  logic                      cond_hit;
  logic                      wait_hit;

  // fetch and condition evaluation
  always_comb begin
    word = arfe_pkg::rom(pc_q);
    unique case (word.cond)
      arfe_pkg::COND_NEVER:    cond_hit = 1'b0;
      arfe_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      arfe_pkg::COND_NO_IN:    cond_hit = ~in_valid_i;
      arfe_pkg::COND_PEAK:     cond_hit = stat_i.peak_mode;
      arfe_pkg::COND_CNT_NZ:   cond_hit = stat_i.cnt_nz;
      arfe_pkg::COND_OUT_FULL: cond_hit = stat_i.out_full;
      default:                 cond_hit = 1'b0;
    endcase
  end

  // waiting steps issue no operation while they hold
  assign wait_hit = cond_hit && ((word.cond == arfe_pkg::COND_NO_IN) ||
                                 (word.cond == arfe_pkg::COND_OUT_FULL));

  always_comb begin
    ctrl_o = word;
    if (wait_hit) begin
      ctrl_o.op = arfe_pkg::OP_NOP;
    end
  end

  assign in_ready_o = (word.op == arfe_pkg::OP_LOAD_IN);
  assign pc_d       = cond_hit ? word.target : pc_q + arfe_pkg::PC_W'(1);

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  `ARFE_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                    "sequencer still takes input right after a transaction")

endmodule

>>> rtl/arfe_dpath.sv
// datapath: detector, shared shift-add multiplier, envelope update,
// digit square root and output register; depends on arfe_pkg and the macros
`include "attack_release_envelope_follower_unit_defines.svh"

module arfe_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  arfe_pkg::arfe_ctrl_t                 ctrl_i,
  input  logic signed [15:0]                   sample_i,
  input  logic                                 mode_i,
  input  logic [arfe_pkg::COEFF_W-1:0]         attack_i,
  input  logic [arfe_pkg::COEFF_W-1:0]         release_i,
  input  logic                                 out_ready_i,
  output arfe_pkg::arfe_stat_t                 stat_o,
  output logic                                 out_valid_o,
  output logic [arfe_pkg::LEVEL_W-1:0]         level_o
);

  localparam int unsigned EW = arfe_pkg::ENV_W;

  logic [EW-1:0]                    env_q, env_d;
  logic [arfe_pkg::CNT_W-1:0]       cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic [arfe_pkg::LEVEL_W-1:0]     out_data_q, out_data_d;
  logic [EW-1:0]                    mul_b_q, mul_b_d;
  logic [arfe_pkg::COEFF_W-1:0]     mul_m_q, mul_m_d;
  logic [arfe_pkg::PROD_W-1:0]      prod_q, prod_d;
  logic [arfe_pkg::DET_W-1:0]       det_q, det_d;
  logic                             rise_q, rise_d;
  logic [31:0]                      rad_q, rad_d;
  logic [17:0]                      rem_q, rem_d;
  logic [15:0]                      root_q, root_d;

  logic [arfe_pkg::MAG_W-1:0]       sext;
  logic [arfe_pkg::MAG_W-1:0]       mag;
  logic [EW-1:0]                    det_fx;
  logic                             rise;
  logic [arfe_pkg::COEFF_W-1:0]     coef;
  logic [arfe_pkg::COEFF_W-1:0]     coef_sat;
  logic [EW-1:0]                    step;
  logic [19:0]                      rem_sh;
  logic [19:0]                      trial;
  logic                             ge;
  logic [arfe_pkg::LEVEL_W-1:0]     peak_level;

  // detector and comparison against the envelope
  assign sext     = {sample_i[15], sample_i};
  assign mag      = sample_i[15] ? (~sext + arfe_pkg::MAG_W'(1)) : sext;
  assign det_fx   = {1'b0, det_q, 16'b0};
  assign rise     = det_fx > env_q;
  assign coef     = rise ? attack_i : release_i;
  assign coef_sat = (coef > arfe_pkg::COEFF_ONE) ? arfe_pkg::COEFF_ONE : coef;
  assign step     = prod_q[EW+15:16];

  // one root digit per step
  assign rem_sh = {rem_q, rad_q[31:30]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  // integer part, clamped after a switch out of rms mode
  assign peak_level = (env_q[EW-1:32] != '0) ? '1 : env_q[31:16];

  // next-state selection driven by the control word
  always_comb begin
    env_d       = env_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_data_d  = out_data_q;
    mul_b_d     = mul_b_q;
    mul_m_d     = mul_m_q;
    prod_d      = prod_q;
    det_d       = det_q;
    rise_d      = rise_q;
    rad_d       = rad_q;
    rem_d       = rem_q;
    root_d      = root_q;
    unique case (ctrl_i.op)
      arfe_pkg::OP_LOAD_IN: begin
        mul_b_d = EW'(mag);
        mul_m_d = mag;
        prod_d  = '0;
        det_d   = arfe_pkg::DET_W'(mag);
        cnt_d   = arfe_pkg::MUL_LAST;
      end
      arfe_pkg::OP_MUL_STEP: begin
        prod_d  = {prod_q[arfe_pkg::PROD_W-2:0], 1'b0} +
                  (mul_m_q[arfe_pkg::COEFF_W-1] ? arfe_pkg::PROD_W'(mul_b_q) : '0);
        mul_m_d = {mul_m_q[arfe_pkg::COEFF_W-2:0], 1'b0};
        cnt_d   = cnt_q - arfe_pkg::CNT_W'(1);
      end
      arfe_pkg::OP_DET_PROD: begin
        det_d = prod_q[arfe_pkg::DET_W-1:0];
      end
      arfe_pkg::OP_DIFF: begin
        rise_d  = rise;
        mul_b_d = rise ? (det_fx - env_q) : (env_q - det_fx);
        mul_m_d = coef_sat;
        prod_d  = '0;
        cnt_d   = arfe_pkg::MUL_LAST;
      end
      arfe_pkg::OP_UPDATE: begin
        env_d = rise_q ? (env_q + step) : (env_q - step);
      end
      arfe_pkg::OP_SQRT_INIT: begin
        rad_d  = env_q[EW-1:16];
        rem_d  = '0;
        root_d = '0;
        cnt_d  = arfe_pkg::SQRT_LAST;
      end
      arfe_pkg::OP_SQRT_STEP: begin
        rem_d  = ge ? 18'(rem_sh - trial) : rem_sh[17:0];
        root_d = {root_q[14:0], ge};
        rad_d  = {rad_q[29:0], 2'b00};
        cnt_d  = cnt_q - arfe_pkg::CNT_W'(1);
      end
      arfe_pkg::OP_EMIT_ROOT: begin
        out_data_d  = root_q;
        out_valid_d = 1'b1;
      end
      arfe_pkg::OP_EMIT_PEAK: begin
        out_data_d  = peak_level;
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control and envelope state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      env_q       <= env_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    mul_b_q    <= mul_b_d;
    mul_m_q    <= mul_m_d;
    prod_q     <= prod_d;
    det_q      <= det_d;
    rise_q     <= rise_d;
    rad_q      <= rad_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
  end

  assign stat_o.cnt_nz    = (cnt_q != '0);
  assign stat_o.peak_mode = ~mode_i;
  assign stat_o.out_full  = out_valid_q & ~out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign level_o          = out_data_q;

  `ARFE_ASSERT_NOW(a_step_bound, ctrl_i.op == arfe_pkg::OP_UPDATE,
                   prod_q[arfe_pkg::PROD_W-1:16] <= {1'b0, mul_b_q},
                   "smoothing step exceeds the envelope difference")
  `ARFE_ASSERT_NOW(a_root_rem_bound, ctrl_i.op == arfe_pkg::OP_SQRT_STEP,
                   rem_q <= {1'b0, root_q, 1'b0},
                   "square root remainder out of range")
  `ARFE_ASSERT_NOW(a_emit_slot_free,
                   ctrl_i.op == arfe_pkg::OP_EMIT_ROOT ||
                   ctrl_i.op == arfe_pkg::OP_EMIT_PEAK,
                   !(out_valid_q && !out_ready_i),
                   "result written over an unread result")

endmodule
